// ===== design/prhs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prhs_pkg: shared types and constants of the hazard scoreboard
// Stage numbering, event kinds, sequencer states, bus widths and the control
// groups that pass between the sequencer, the stage file and the counters.
// ----------------------------------------------------------------------------
package prhs_pkg;

  // defaults for the top level parameters
  localparam int DEF_NUM_STAGES   = 8;
  localparam int DEF_REG_COUNT    = 32;
  localparam int DEF_COUNTER_BITS = 32;

  // fixed stage positions (WB is NUM_STAGES-1)
  localparam int STG_IF1  = 0;
  localparam int STG_ID   = 2;
  localparam int STG_EXE1 = 3;
  localparam int STG_MEM2 = 6;

  // field widths
  localparam int KIND_W    = 3;
  localparam int REG_NUM_W = 5;
  localparam int STAGE_W   = 3;
  localparam int REPEAT_W  = 4;
  localparam int ADDED_W   = 4;
  localparam int OUT_W     = 32;

  // counter bank
  localparam int NUM_CNT   = 9;
  localparam int CNT_CYCLE = 0;
  localparam int CNT_FLUSH = 1;
  localparam int CNT_BUBBLE = 2;
  localparam int CNT_STALL = 3;
  localparam int CNT_HAZARD = 4;
  localparam int CNT_EXE1  = 5;
  localparam int CNT_EXE2  = 6;
  localparam int CNT_MEM1  = 7;
  localparam int CNT_MEM2  = 8;

  // bus widths
  localparam int S_TDATA_RAW = REG_NUM_W + STAGE_W + REPEAT_W;
  localparam int S_TDATA_W   = ((S_TDATA_RAW + 7) / 8) * 8;
  localparam int S_TUSER_W   = KIND_W;
  localparam int M_TDATA_RAW = ADDED_W + NUM_CNT * OUT_W;
  localparam int M_TDATA_W   = ((M_TDATA_RAW + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADVANCE = 3'd0,
    KIND_CHECK   = 3'd1,
    KIND_RECORD  = 3'd2,
    KIND_FLUSH   = 3'd3,
    KIND_STALL   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ONE,
    S_SCAN,
    S_BUBBLE,
    S_REPEAT,
    S_FINISH
  } state_t;

  // stage file operation
  typedef struct packed {
    logic shift;   // advance from the given stage
    logic record;  // write ID
  } stg_op_t;

  // counter increments
  typedef struct packed {
    logic       cycles;
    logic       flushes;
    logic       bubbles;
    logic       stalls;
    logic       hazards;
    logic [3:0] by_stage;  // one-hot: EXE1, EXE2, MEM1, MEM2 from bit 0
  } cnt_bump_t;

endpackage

// ===== design/prhs_stage_file.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prhs_stage_file: pipeline stage registers
// Holds tag, valid and ready stage per pipeline stage. One shift unit moves
// the stages above a start stage up by one; one read port serves the scan.
// ----------------------------------------------------------------------------
module prhs_stage_file #(
  parameter int NUM_STAGES = prhs_pkg::DEF_NUM_STAGES,
  parameter int REG_COUNT  = prhs_pkg::DEF_REG_COUNT,
  localparam int TAG_W = $clog2(REG_COUNT),
  localparam int IDX_W = $clog2(NUM_STAGES),
  localparam int SEL_W = (IDX_W > 3) ? IDX_W : 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  prhs_pkg::stg_op_t             op,
  input  logic [SEL_W-1:0]              from,
  input  logic [TAG_W-1:0]              wr_tag,
  input  logic [prhs_pkg::STAGE_W-1:0]  wr_ready,
  input  logic [IDX_W-1:0]              rd_idx,
  output logic                          rd_valid,
  output logic [TAG_W-1:0]              rd_tag,
  output logic [prhs_pkg::STAGE_W-1:0]  rd_ready
);
  import prhs_pkg::*;

  logic [TAG_W-1:0]   tag   [NUM_STAGES];
  logic               valid [NUM_STAGES];
  logic [STAGE_W-1:0] ready [NUM_STAGES];

  // ready stage is read only for valid stages, so it needs no reset
  always_ff @(posedge clk) begin
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (op.shift && i > int'(from)) begin
        ready[i] <= ready[i-1];
      end
    end
    if (op.record) begin
      ready[STG_ID] <= wr_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        tag[i]   <= '0;
        valid[i] <= 1'b0;
      end
    end else if (op.shift) begin
      // a start stage beyond WB matches no stage and shifts nothing
      if (from == '0) begin
        valid[0] <= 1'b0;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (i > int'(from)) begin
          tag[i]   <= tag[i-1];
          valid[i] <= valid[i-1];
        end else if (i == int'(from)) begin
          valid[i] <= 1'b0;
        end
      end
    end else if (op.record) begin
      tag[STG_ID]   <= wr_tag;
      valid[STG_ID] <= 1'b1;
    end
  end

  assign rd_valid = valid[rd_idx];
  assign rd_tag   = tag[rd_idx];
  assign rd_ready = ready[rd_idx];

endmodule

// ===== design/prhs_counters.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prhs_counters: running event counters
// Nine wrapping counters: cycles, flushes, bubbles, stalls, hazards and
// hazards by producer stage.
// ----------------------------------------------------------------------------
module prhs_counters #(
  parameter int NUM_STAGES   = prhs_pkg::DEF_NUM_STAGES,
  parameter int COUNTER_BITS = prhs_pkg::DEF_COUNTER_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  prhs_pkg::cnt_bump_t     bump,
  output logic [COUNTER_BITS-1:0] count [prhs_pkg::NUM_CNT]
);
  import prhs_pkg::*;

  logic [NUM_CNT-1:0] inc;

  always_comb begin
    inc             = '0;
    inc[CNT_CYCLE]  = bump.cycles;
    inc[CNT_FLUSH]  = bump.flushes;
    inc[CNT_BUBBLE] = bump.bubbles;
    inc[CNT_STALL]  = bump.stalls;
    inc[CNT_HAZARD] = bump.hazards;
    inc[CNT_EXE1]   = bump.by_stage[0];
    inc[CNT_EXE2]   = bump.by_stage[1];
    inc[CNT_MEM1]   = bump.by_stage[2];
    inc[CNT_MEM2]   = bump.by_stage[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CNT; i++) begin
        count[i] <= (i == CNT_CYCLE) ? COUNTER_BITS'(NUM_STAGES - 1) : '0;
      end
    end else begin
      for (int i = 0; i < NUM_CNT; i++) begin
        if (inc[i]) begin
          count[i] <= count[i] + COUNTER_BITS'(1);
        end
      end
    end
  end

endmodule

// ===== design/prhs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prhs_ctrl: event sequencer
// Takes one event word, then steps the stage file one shift or one scan
// position per cycle and raises the counter increments.
// ----------------------------------------------------------------------------
module prhs_ctrl #(
  parameter int NUM_STAGES = prhs_pkg::DEF_NUM_STAGES,
  parameter int REG_COUNT  = prhs_pkg::DEF_REG_COUNT,
  localparam int TAG_W = $clog2(REG_COUNT),
  localparam int IDX_W = $clog2(NUM_STAGES),
  localparam int SEL_W = (IDX_W > 3) ? IDX_W : 3
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  prhs_pkg::kind_t                in_kind,
  input  logic [prhs_pkg::REG_NUM_W-1:0] in_reg,
  input  logic [prhs_pkg::STAGE_W-1:0]   in_stage,
  input  logic [prhs_pkg::REPEAT_W-1:0]  in_count,
  input  logic                           out_free,
  output logic                           load_out,
  output logic [prhs_pkg::ADDED_W-1:0]   added,
  output prhs_pkg::stg_op_t              op,
  output logic [SEL_W-1:0]               from,
  output logic [TAG_W-1:0]               wr_tag,
  output logic [prhs_pkg::STAGE_W-1:0]   wr_ready,
  output logic [IDX_W-1:0]               rd_idx,
  input  logic                           rd_valid,
  input  logic [TAG_W-1:0]               rd_tag,
  input  logic [prhs_pkg::STAGE_W-1:0]   rd_ready,
  output prhs_pkg::cnt_bump_t            bump
);
  import prhs_pkg::*;

  localparam int NW = IDX_W + 3;
  localparam int RW = 7;

  state_t              state, state_next;
  kind_t               kind;
  logic [TAG_W-1:0]    tag;
  logic [STAGE_W-1:0]  stage;
  logic [REPEAT_W-1:0] rem, rem_next;
  logic [IDX_W-1:0]    idx, idx_next;
  logic [ADDED_W-1:0]  added_next;
  logic [RW-1:0]       reg_red;
  logic [TAG_W-1:0]    in_tag;
  logic                hit;
  logic signed [NW-1:0] need;

  // register number modulo REG_COUNT: at most a few subtractions
  always_comb begin
    reg_red = RW'(in_reg);
    for (int k = 0; k < 4; k++) begin
      if (reg_red >= RW'(REG_COUNT)) begin
        reg_red = reg_red - RW'(REG_COUNT);
      end
    end
  end
  assign in_tag = TAG_W'(reg_red);

  assign rd_idx   = idx;
  assign wr_tag   = tag;
  assign wr_ready = stage;
  assign hit      = rd_valid && (rd_tag == tag);
  // bubbles = (ready - i) - (needed - ID)
  assign need = NW'(rd_ready) + NW'(STG_ID) - NW'(idx) - NW'(stage);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind  <= in_kind;
      tag   <= in_tag;
      stage <= in_stage;
    end
    rem   <= rem_next;
    idx   <= idx_next;
    added <= added_next;
  end

  always_comb begin
    state_next = state;
    rem_next   = rem;
    idx_next   = idx;
    added_next = added;
    in_ready   = 1'b0;
    load_out   = 1'b0;
    op         = '0;
    from       = '0;
    bump       = '0;
    unique case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        rem_next   = in_count;
        idx_next   = IDX_W'(STG_EXE1);
        added_next = '0;
        if (in_valid) begin
          unique case (in_kind)
            KIND_CHECK:
              state_next = (in_tag == '0) ? S_FINISH : S_SCAN;
            KIND_FLUSH, KIND_STALL:
              state_next = (in_count == '0) ? S_FINISH : S_REPEAT;
            default:
              state_next = S_ONE;
          endcase
        end
      end
      S_ONE: begin
        unique case (kind)
          KIND_ADVANCE: begin
            op.shift    = 1'b1;
            from        = SEL_W'(stage);
            bump.cycles = 1'b1;
          end
          KIND_RECORD: op.record = 1'b1;
          default: ;
        endcase
        state_next = S_FINISH;
      end
      S_SCAN: begin
        if (hit) begin
          bump.hazards = 1'b1;
          if (idx <= IDX_W'(STG_MEM2)) begin
            bump.by_stage = 4'b0001 << 2'(idx - IDX_W'(STG_EXE1));
          end
          if (!need[NW-1] && need != '0) begin
            rem_next   = REPEAT_W'(need);
            state_next = S_BUBBLE;
          end else begin
            state_next = S_FINISH;
          end
        end else if (idx == IDX_W'(NUM_STAGES - 2)) begin
          state_next = S_FINISH;
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end
      S_BUBBLE: begin
        op.shift     = 1'b1;
        from         = SEL_W'(STG_EXE1);
        bump.cycles  = 1'b1;
        bump.bubbles = 1'b1;
        added_next   = added + ADDED_W'(1);
        rem_next     = rem - REPEAT_W'(1);
        if (rem == REPEAT_W'(1)) begin
          state_next = S_FINISH;
        end
      end
      S_REPEAT: begin
        op.shift    = 1'b1;
        bump.cycles = 1'b1;
        if (kind == KIND_FLUSH) begin
          from         = SEL_W'(STG_IF1);
          bump.flushes = 1'b1;
        end else begin
          from        = SEL_W'(NUM_STAGES - 1);
          bump.stalls = 1'b1;
        end
        rem_next = rem - REPEAT_W'(1);
        if (rem == REPEAT_W'(1)) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_rem_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_BUBBLE || state == S_REPEAT) |-> rem != '0)
    else $error("repeat count exhausted inside a repeat loop");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> (idx >= IDX_W'(STG_EXE1) && idx <= IDX_W'(NUM_STAGES - 2)))
    else $error("scan index left EXE1..WB-1");

  a_shift_counts: assert property (@(posedge clk) disable iff (rst)
    op.shift |-> bump.cycles && !op.record)
    else $error("stage shift without a cycle count");

  a_accept_leaves: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state != S_IDLE)
    else $error("accepted word did not start the sequencer");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> out_free && state == S_FINISH)
    else $error("result loaded over an untaken word");

endmodule

// ===== design/pipeline_raw_hazard_scoreboard.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipeline_raw_hazard_scoreboard: in-order pipeline RAW hazard scoreboard
// Event words in on the s_ side, one result word per event out on m_ side.
//
// s_tuser carries the event kind (advance, source check, destination record,
// flush, stall); s_tdata carries register, stage and repeat count. Each event
// gives one m_tdata word: bubbles added by this event and all running totals.
// An event is accepted, then the sequencer steps through its stage shifts or
// scan positions and then loads the result register: advance makes one
// shift, record one write, flush and stall one shift per repeat count, and a
// source check scans the stages and then shifts in its bubbles. The sequencer
// steps one shift of the stage file per cycle; s_tready is high only between
// events. The result sits in an output register, so the next event is
// taken while a result waits; a stalled receiver holds the block only once
// the next result is ready too. Reset empties every stage, sets the cycle
// count to NUM_STAGES-1 and clears the other counters; it needs no pass.
// ----------------------------------------------------------------------------
module pipeline_raw_hazard_scoreboard #(
  parameter int NUM_STAGES   = prhs_pkg::DEF_NUM_STAGES,
  parameter int REG_COUNT    = prhs_pkg::DEF_REG_COUNT,
  parameter int COUNTER_BITS = prhs_pkg::DEF_COUNTER_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [4:0] reg_num, [7:5] stage_num, [11:8] repeat_count
  input  logic [prhs_pkg::S_TDATA_W-1:0] s_tdata,
  // [2:0] kind
  input  logic [prhs_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [3:0] bubbles_added, [35:4] cycle_count, [67:36] flush_count,
  // [99:68] bubble_count, [131:100] stall_count, [163:132] raw_hazard_count,
  // [195:164] exe_one_hazards, [227:196] exe_two_hazards,
  // [259:228] mem_one_hazards, [291:260] mem_two_hazards
  output logic [prhs_pkg::M_TDATA_W-1:0] m_tdata
);
  import prhs_pkg::*;

  localparam int TAG_W = $clog2(REG_COUNT);
  localparam int IDX_W = $clog2(NUM_STAGES);
  localparam int SEL_W = (IDX_W > 3) ? IDX_W : 3;
  localparam int PAD_W = M_TDATA_W - M_TDATA_RAW;

  stg_op_t               op;
  cnt_bump_t             bump;
  logic [SEL_W-1:0]      from;
  logic [TAG_W-1:0]      wr_tag;
  logic [STAGE_W-1:0]    wr_ready;
  logic [IDX_W-1:0]      rd_idx;
  logic                  rd_valid;
  logic [TAG_W-1:0]      rd_tag;
  logic [STAGE_W-1:0]    rd_ready;
  logic [ADDED_W-1:0]    added;
  logic                  load_out;
  logic                  out_free;
  logic [COUNTER_BITS-1:0] count [NUM_CNT];
  logic [M_TDATA_RAW-1:0]  result;

  prhs_ctrl #(
    .NUM_STAGES (NUM_STAGES),
    .REG_COUNT  (REG_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_kind  (kind_t'(s_tuser[KIND_W-1:0])),
    .in_reg   (s_tdata[REG_NUM_W-1:0]),
    .in_stage (s_tdata[REG_NUM_W +: STAGE_W]),
    .in_count (s_tdata[REG_NUM_W + STAGE_W +: REPEAT_W]),
    .out_free (out_free),
    .load_out (load_out),
    .added    (added),
    .op       (op),
    .from     (from),
    .wr_tag   (wr_tag),
    .wr_ready (wr_ready),
    .rd_idx   (rd_idx),
    .rd_valid (rd_valid),
    .rd_tag   (rd_tag),
    .rd_ready (rd_ready),
    .bump     (bump)
  );

  prhs_stage_file #(
    .NUM_STAGES (NUM_STAGES),
    .REG_COUNT  (REG_COUNT)
  ) u_stages (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .from     (from),
    .wr_tag   (wr_tag),
    .wr_ready (wr_ready),
    .rd_idx   (rd_idx),
    .rd_valid (rd_valid),
    .rd_tag   (rd_tag),
    .rd_ready (rd_ready)
  );

  prhs_counters #(
    .NUM_STAGES   (NUM_STAGES),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_counters (
    .clk   (clk),
    .rst   (rst),
    .bump  (bump),
    .count (count)
  );

  always_comb begin
    result = {OUT_W'(count[CNT_MEM2]), OUT_W'(count[CNT_MEM1]),
              OUT_W'(count[CNT_EXE2]), OUT_W'(count[CNT_EXE1]),
              OUT_W'(count[CNT_HAZARD]), OUT_W'(count[CNT_STALL]),
              OUT_W'(count[CNT_BUBBLE]), OUT_W'(count[CNT_FLUSH]),
              OUT_W'(count[CNT_CYCLE]), added};
  end

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {{PAD_W{1'b0}}, result};
    end
  end

endmodule

// ===== sim/hazard_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hazard_checker: result predictor and comparator for the hazard scoreboard
// Watches both stream channels. Each accepted event word runs through a local
// copy of the stage file and counters; the predicted result word is queued and
// compared field by field with the next result word taken from the block.
// ----------------------------------------------------------------------------
module hazard_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [prhs_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [prhs_pkg::S_TUSER_W-1:0] s_tuser,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [prhs_pkg::M_TDATA_W-1:0] m_tdata,
  output int                             errors,
  output int                             pending
);
  import prhs_pkg::*;

  localparam int STAGES = DEF_NUM_STAGES;
  localparam int STG_WB = STAGES - 1;
  localparam int NUM_FIELDS = NUM_CNT + 1;

  logic [REG_NUM_W-1:0] tag_q [STAGES];
  logic                 vld_q [STAGES];
  logic [STAGE_W-1:0]   rdy_q [STAGES];
  logic [OUT_W-1:0]     totals [NUM_CNT];

  logic [M_TDATA_W-1:0] result_fifo [$];
  logic [M_TDATA_W-1:0] want;
  logic [M_TDATA_W-1:0] next_word;
  logic [31:0]          exp_v;
  logic [31:0]          got_v;
  int                   lo;
  int                   mismatches;

  string field_name [NUM_FIELDS] = '{"bubbles_added", "cycle_count", "flush_count",
    "bubble_count", "stall_count", "raw_hazard_count", "exe_one_hazards",
    "exe_two_hazards", "mem_one_hazards", "mem_two_hazards"};

  initial begin
    mismatches = 0;
  end

  // pipeline advance: shift from 'from' toward WB, empty 'from', bump the cycle count
  task automatic shift_from(input int from);
    totals[CNT_CYCLE] = totals[CNT_CYCLE] + 1;
    if (from < STAGES) begin
      for (int i = STG_WB; i > from; i--) begin
        tag_q[i] = tag_q[i-1];
        vld_q[i] = vld_q[i-1];
        rdy_q[i] = rdy_q[i-1];
      end
      vld_q[from] = 1'b0;
    end
  endtask

  task automatic predict_event(input logic [KIND_W-1:0] kind, input logic [REG_NUM_W-1:0] rn,
                               input logic [STAGE_W-1:0] sn, input logic [REPEAT_W-1:0] cnt,
                               output logic [M_TDATA_W-1:0] word);
    logic [ADDED_W-1:0] added;
    int                 n;
    bit                 found;
    added = '0;
    found = 1'b0;
    case (kind)
      KIND_ADVANCE: shift_from(int'(sn));
      KIND_CHECK: begin
        if (rn != '0) begin
          // nearest producer wins; WB is not scanned
          for (int i = STG_EXE1; i < STG_WB; i++) begin
            if (!found && vld_q[i] && tag_q[i] == rn) begin
              found = 1'b1;
              if (i <= STG_MEM2)
                totals[CNT_EXE1 + i - STG_EXE1] = totals[CNT_EXE1 + i - STG_EXE1] + 1;
              totals[CNT_HAZARD] = totals[CNT_HAZARD] + 1;
              n = (int'(rdy_q[i]) - i) - (int'(sn) - STG_ID);
              while (n > 0) begin
                totals[CNT_BUBBLE] = totals[CNT_BUBBLE] + 1;
                shift_from(STG_EXE1);
                added = added + ADDED_W'(1);
                n--;
              end
            end
          end
        end
      end
      KIND_RECORD: begin
        tag_q[STG_ID] = rn;
        vld_q[STG_ID] = 1'b1;
        rdy_q[STG_ID] = sn;
      end
      KIND_FLUSH: begin
        for (int k = 0; k < int'(cnt); k++) begin
          shift_from(STG_IF1);
          totals[CNT_FLUSH] = totals[CNT_FLUSH] + 1;
        end
      end
      KIND_STALL: begin
        for (int k = 0; k < int'(cnt); k++) begin
          shift_from(STG_WB);
          totals[CNT_STALL] = totals[CNT_STALL] + 1;
        end
      end
      default: ;
    endcase
    word = '0;
    word[ADDED_W-1:0] = added;
    for (int k = 0; k < NUM_CNT; k++)
      word[ADDED_W + OUT_W*k +: OUT_W] = totals[k];
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STAGES; i++) begin
        tag_q[i] = '0;
        vld_q[i] = 1'b0;
        rdy_q[i] = '0;
      end
      for (int k = 0; k < NUM_CNT; k++)
        totals[k] = '0;
      totals[CNT_CYCLE] = STAGES - 1;
      result_fifo.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (result_fifo.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result word with no event pending: %h", $realtime, m_tdata);
          mismatches++;
        end else begin
          want = result_fifo.pop_front();
          for (int f = 0; f < NUM_FIELDS; f++) begin
            lo = (f == 0) ? 0 : ADDED_W + OUT_W*(f-1);
            exp_v = want[lo +: 32] & ((f == 0) ? 32'hF : 32'hFFFF_FFFF);
            got_v = m_tdata[lo +: 32] & ((f == 0) ? 32'hF : 32'hFFFF_FFFF);
            if (exp_v !== got_v) begin
              if (mismatches < 10)
                $display("%0t: mismatch on %s: expected %0d, got %0d",
                         $realtime, field_name[f], exp_v, got_v);
              mismatches++;
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        predict_event(s_tuser, s_tdata[REG_NUM_W-1:0],
                      s_tdata[REG_NUM_W +: STAGE_W],
                      s_tdata[REG_NUM_W+STAGE_W +: REPEAT_W], next_word);
        result_fifo.push_back(next_word);
      end
    end
    errors  <= mismatches;
    pending <= result_fifo.size();
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the RAW hazard scoreboard
// Directed events cover the corner cases, then mostly record/advance/check
// instruction sequences on a small register pool with random noise mixed in.
// Both channels idle at random; the receiver holds off once for a long
// stretch. The checker beside the block predicts and compares every word.
// ----------------------------------------------------------------------------
module testbench;
  import prhs_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE0 = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE1 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE2 = 3'd7;
  localparam int RANDOM_EVENTS = 1700;
  localparam int HOLD_START    = 3000;
  localparam int HOLD_LEN      = 400;
  localparam int IDLE_LIMIT    = 4000;
  localparam int DRAIN_CYCLES  = 40;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  int                   errors;
  int                   pending;

  bit calm = 1'b0;
  int events_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pipeline_raw_hazard_scoreboard dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  hazard_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(errors), .pending(pending)
  );

  task automatic send_event(input logic [KIND_W-1:0] kind, input logic [REG_NUM_W-1:0] rn,
                            input logic [STAGE_W-1:0] sn, input logic [REPEAT_W-1:0] cnt);
    while (!calm && $urandom_range(99) < 16) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= S_TDATA_W'({cnt, sn, rn});
    do @(posedge clk); while (!s_tready);
    events_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // mostly a few hot registers so producers and consumers meet
  function automatic logic [REG_NUM_W-1:0] pick_reg();
    return ($urandom_range(3) == 0) ? REG_NUM_W'($urandom_range(31))
                                    : REG_NUM_W'($urandom_range(1, 4));
  endfunction

  initial begin
    logic [REG_NUM_W-1:0] rn;
    bit paused;
    paused = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // spare kinds only report the totals
    send_event(KIND_SPARE0, 5'd31, 3'd7, 4'd15);
    send_event(KIND_SPARE2, 5'd0, 3'd0, 4'd0);
    // register zero never hazards, even when recorded
    send_event(KIND_RECORD, 5'd0, 3'd7, 4'd0);
    send_event(KIND_ADVANCE, 5'd0, 3'd0, 4'd0);
    send_event(KIND_CHECK, 5'd0, 3'd0, 4'd0);
    // EXE1 producer, late ready: four bubbles
    send_event(KIND_RECORD, 5'd31, 3'd7, 4'd15);
    send_event(KIND_ADVANCE, 5'd0, 3'd0, 4'd0);
    send_event(KIND_CHECK, 5'd31, 3'd2, 4'd0);
    // EXE1 hazard, consumer late: none needed
    send_event(KIND_RECORD, 5'd5, 3'd4, 4'd0);
    send_event(KIND_ADVANCE, 5'd0, 3'd2, 4'd0);
    send_event(KIND_CHECK, 5'd5, 3'd7, 4'd0);
    // EXE2 producer, then MEM2 after the bubbles
    send_event(KIND_ADVANCE, 5'd0, 3'd3, 4'd0);
    send_event(KIND_CHECK, 5'd5, 3'd0, 4'd0);
    send_event(KIND_CHECK, 5'd5, 3'd2, 4'd0);
    // MEM1 producer
    send_event(KIND_RECORD, 5'd9, 3'd7, 4'd0);
    send_event(KIND_ADVANCE, 5'd0, 3'd1, 4'd0);
    send_event(KIND_ADVANCE, 5'd0, 3'd0, 4'd0);
    send_event(KIND_ADVANCE, 5'd0, 3'd0, 4'd0);
    send_event(KIND_CHECK, 5'd9, 3'd2, 4'd0);
    // a check that finds no producer; WB holds register 9, which is not scanned
    send_event(KIND_CHECK, 5'd31, 3'd0, 4'd0);
    send_event(KIND_ADVANCE, 5'd0, 3'd7, 4'd0);
    send_event(KIND_FLUSH, 5'd0, 3'd0, 4'd0);
    send_event(KIND_FLUSH, 5'd31, 3'd7, 4'd15);
    send_event(KIND_STALL, 5'd0, 3'd0, 4'd0);
    send_event(KIND_STALL, 5'd31, 3'd7, 4'd15);
    send_event(KIND_SPARE1, 5'd21, 3'd5, 4'd10);
    wait_drained();

    events_sent = 0;
    while (events_sent < RANDOM_EVENTS) begin
      calm = (events_sent >= 700 && events_sent < 1000);
      if (!paused && events_sent >= 1200) begin
        paused = 1'b1;
        wait_drained();
      end
      if ($urandom_range(99) < 70) begin
        rn = pick_reg();
        send_event(KIND_RECORD, rn, STAGE_W'($urandom_range(7)),
                   REPEAT_W'($urandom_range(15)));
        repeat ($urandom_range(1, 3))
          send_event(KIND_ADVANCE, REG_NUM_W'($urandom_range(31)),
                     STAGE_W'($urandom_range(3)), REPEAT_W'($urandom_range(15)));
        send_event(KIND_CHECK, ($urandom_range(2) == 0) ? pick_reg() : rn,
                   STAGE_W'($urandom_range(7)), REPEAT_W'($urandom_range(15)));
      end else begin
        send_event(KIND_W'($urandom_range(7)), REG_NUM_W'($urandom_range(31)),
                   STAGE_W'($urandom_range(7)), REPEAT_W'($urandom_range(15)));
      end
    end
    calm = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // result side: random backpressure plus one long hold-off
  initial begin
    int rx_cycle;
    rx_cycle = 0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
        m_tready <= 1'b0;
      else if (calm)
        m_tready <= 1'b1;
      else
        m_tready <= ($urandom_range(99) >= 16);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule
